// ----- hdl/pose_dead_reckoning_integrator_top_defines.svh -----
// Assertion macros for the pose integrator; they use the clk and rst of the enclosing module.
`ifndef POSE_DEAD_RECKONING_INTEGRATOR_TOP_DEFINES_SVH
`define POSE_DEAD_RECKONING_INTEGRATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define PDR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/pdr_pkg.sv -----
`timescale 1ns / 1ps

package pdr_pkg;

  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_ITERS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int STEP_W       = $clog2(TABLE_LEN);

  // CORDIC datapath: Q30 vector, 2^32-per-turn angle, with headroom
  localparam int CW = 34;

  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW-1:0] QUARTER_TURN    = 34'sd1073741824;
  localparam logic signed [CW-1:0] HALF_TURN       = 34'sd2147483648;

  typedef struct packed {
    logic               start;
    logic signed [31:0] angle;
  } cord_req_t;

  typedef struct packed {
    logic                  busy;
    logic signed [CW-1:0]  cos_q30;
    logic signed [CW-1:0]  sin_q30;
  } cord_rsp_t;

  // arctangent of 2^-i in 2^32-per-turn units
  function automatic logic [29:0] atan_step(input logic [STEP_W-1:0] idx);
    logic [29:0] r;
    unique case (idx)
      5'd0:    r = 30'd536870912;
      5'd1:    r = 30'd316933406;
      5'd2:    r = 30'd167458907;
      5'd3:    r = 30'd85004756;
      5'd4:    r = 30'd42667331;
      5'd5:    r = 30'd21354465;
      5'd6:    r = 30'd10679838;
      5'd7:    r = 30'd5340245;
      5'd8:    r = 30'd2670163;
      5'd9:    r = 30'd1335087;
      5'd10:   r = 30'd667544;
      5'd11:   r = 30'd333772;
      5'd12:   r = 30'd166886;
      5'd13:   r = 30'd83443;
      5'd14:   r = 30'd41722;
      5'd15:   r = 30'd20861;
      5'd16:   r = 30'd10430;
      5'd17:   r = 30'd5215;
      5'd18:   r = 30'd2608;
      5'd19:   r = 30'd1304;
      5'd20:   r = 30'd652;
      5'd21:   r = 30'd326;
      5'd22:   r = 30'd163;
      5'd23:   r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/pose_dead_reckoning_integrator_top.sv -----
`timescale 1ns / 1ps
// Dead-reckoning pose integrator for a differential-drive base.
// Input stream (s_*): one beat per update with linear velocity, yaw rate and
// elapsed time. Output stream (m_*): one beat per update with the new x, y,
// heading, yaw quaternion (z, w) and the two velocities echoed back.
// Each update runs two rotations through one shared iterative CORDIC unit
// (old heading for the position step, then half the new heading for the
// quaternion), each one iteration per cycle, while one shared 33x18
// multiplier works out v*dt, the heading step and the x/y steps in partial
// products, each product registered before it is folded in, alongside the CORDIC.
// Each beat passes through the rotation states ROT1 and ROT2 and then DONE,
// and a new beat is taken only once the sequencer is back in idle, not while
// the last one is worked on. s_tready is high only while the sequencer idles.
// The result sits in an output register: if the receiver stalls, the next beat
// is still taken and worked on, and it waits at the end for the register.
// Reset (rst, synchronous) clears the pose to zero and empties both sides.
`include "pose_dead_reckoning_integrator_top_defines.svh"

module pose_dead_reckoning_integrator_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // linear_velocity[15:0], angular_velocity[31:16], elapsed_time[47:32]
  input  logic [47:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // position_x[31:0], position_y[63:32], heading[79:64], quat_z[95:80],
  // quat_w[111:96], speed_linear[127:112], speed_angular[143:128]
  output logic [143:0] m_tdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROT1 = 2'd1;
  localparam logic [1:0] ST_ROT2 = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [2:0] OP_WDT = 3'd0;
  localparam logic [2:0] OP_HLO = 3'd1;
  localparam logic [2:0] OP_HHI = 3'd2;
  localparam logic [2:0] OP_VDT = 3'd3;
  localparam logic [2:0] OP_XLO = 3'd4;
  localparam logic [2:0] OP_XHI = 3'd5;
  localparam logic [2:0] OP_YLO = 3'd6;
  localparam logic [2:0] OP_YHI = 3'd7;

  localparam logic [3:0] OP_END1 = 4'd4;
  localparam logic [3:0] OP_END2 = 4'd8;

  // 2^32/pi split into a 17-bit low and a 14-bit high partial constant
  localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
  localparam logic [16:0] INV_PI_LO  = INV_PI_Q32[16:0];
  localparam logic [13:0] INV_PI_HI  = INV_PI_Q32[30:17];

  localparam logic signed [67:0] RND_HEAD = 68'sd1 <<< 44;
  localparam logic signed [67:0] RND_POS  = 68'sd1 <<< 41;

  logic [1:0]          state;
  logic [3:0]          mop;
  logic                pv;

  logic signed [15:0]  lin_v;
  logic signed [15:0]  ang_v;
  logic [15:0]         dt;
  logic signed [32:0]  wdt;
  logic signed [32:0]  vdt;
  logic signed [67:0]  acc;
  logic signed [50:0]  prod;
  logic signed [pdr_pkg::CW-1:0] c_q;
  logic signed [pdr_pkg::CW-1:0] s_q;

  logic signed [31:0]  pose_x;
  logic signed [31:0]  pose_y;
  logic [15:0]         pose_heading;

  logic signed [32:0]  mul_a;
  logic signed [17:0]  mul_b;
  logic signed [50:0]  mul_p;
  logic                mul_go;
  logic signed [67:0]  prod_ext;
  logic signed [67:0]  acc_sum;
  logic signed [67:0]  rnd_h;
  logic signed [67:0]  rnd_p;
  logic                rot1_done;
  logic                rot2_done;

  pdr_pkg::cord_req_t  cord_req;
  pdr_pkg::cord_rsp_t  cord_rsp;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                 input logic signed [25:0] d);
    logic signed [33:0] s;
    logic signed [31:0] r;
    s = 34'(p) + 34'(d);
    priority if (s > 34'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (s < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] to_q15(input logic signed [pdr_pkg::CW-1:0] v);
    logic signed [pdr_pkg::CW-1:0] r;
    logic signed [18:0]            t;
    logic [15:0]                   q;
    r = v + 34'sd16384;
    t = r[33:15];
    priority if (t > 19'sd32767) begin
      q = 16'h7fff;
    end else if (t < -19'sd32768) begin
      q = 16'h8000;
    end else begin
      q = t[15:0];
    end
    return q;
  endfunction

  pdr_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (cord_req),
    .rsp (cord_rsp)
  );

  assign s_tready  = (state == ST_IDLE);
  assign rot1_done = (state == ST_ROT1) && !cord_rsp.busy && (mop == OP_END1);
  assign rot2_done = (state == ST_ROT2) && !cord_rsp.busy && (mop == OP_END2);
  assign mul_go    = ((state == ST_ROT1) && (mop < OP_END1)) ||
                     ((state == ST_ROT2) && (mop < OP_END2));

  always_comb begin
    cord_req.start = (s_tvalid && s_tready) || rot1_done;
    if (state == ST_IDLE) begin
      cord_req.angle = {s_tready ? pose_heading : pose_heading, 16'h0000};
    end else begin
      cord_req.angle = {pose_heading[15], pose_heading, 15'h0000};
    end
  end

  always_comb begin
    unique case (mop[2:0])
      OP_WDT: begin
        mul_a = 33'(ang_v);
        mul_b = {2'b00, dt};
      end
      OP_HLO: begin
        mul_a = wdt;
        mul_b = {1'b0, INV_PI_LO};
      end
      OP_HHI: begin
        mul_a = wdt;
        mul_b = {4'b0000, INV_PI_HI};
      end
      OP_VDT: begin
        mul_a = 33'(lin_v);
        mul_b = {2'b00, dt};
      end
      OP_XLO: begin
        mul_a = vdt;
        mul_b = {1'b0, c_q[16:0]};
      end
      OP_XHI: begin
        mul_a = vdt;
        mul_b = c_q[33:16];
      end
      OP_YLO: begin
        mul_a = vdt;
        mul_b = {1'b0, s_q[16:0]};
      end
      OP_YHI: begin
        mul_a = vdt;
        mul_b = s_q[33:16];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // high partials use bits [33:17]; bit 16 is dropped by the arithmetic shift below
  logic signed [17:0] mul_b_eff;
  assign mul_b_eff = ((mop[2:0] == OP_XHI) || (mop[2:0] == OP_YHI)) ?
                     (mul_b >>> 1) : mul_b;
  assign mul_p     = 51'(mul_a) * 51'(mul_b_eff);

  assign prod_ext = 68'(prod);
  assign acc_sum  = acc + (prod_ext <<< 17);
  assign rnd_h    = acc_sum + RND_HEAD;
  assign rnd_p    = acc_sum + RND_POS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      mop          <= '0;
      pv           <= 1'b0;
      m_tvalid     <= 1'b0;
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end

      if (mul_go) begin
        if (!pv) begin
          prod <= mul_p;
          pv   <= 1'b1;
        end else begin
          pv  <= 1'b0;
          mop <= mop + 1'b1;
          unique case (mop[2:0])
            OP_WDT: wdt <= prod[32:0];
            OP_HLO: acc <= prod_ext;
            OP_HHI: pose_heading <= pose_heading + rnd_h[60:45];
            OP_VDT: vdt <= prod[32:0];
            OP_XLO: acc <= prod_ext;
            OP_XHI: pose_x <= sat_add(pose_x, rnd_p[67:42]);
            OP_YLO: acc <= prod_ext;
            OP_YHI: pose_y <= sat_add(pose_y, rnd_p[67:42]);
            default: acc <= acc;
          endcase
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            lin_v <= s_tdata[15:0];
            ang_v <= s_tdata[31:16];
            dt    <= s_tdata[47:32];
            mop   <= '0;
            pv    <= 1'b0;
            state <= ST_ROT1;
          end
        end
        ST_ROT1: begin
          if (rot1_done) begin
            c_q   <= cord_rsp.cos_q30;
            s_q   <= cord_rsp.sin_q30;
            state <= ST_ROT2;
          end
        end
        ST_ROT2: begin
          if (rot2_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {ang_v, lin_v, to_q15(cord_rsp.cos_q30),
                         to_q15(cord_rsp.sin_q30), pose_heading, pose_y, pose_x};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `PDR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "beat taken while busy")
  `PDR_ASSERT_SAME(a_rot2_after_heading, state == ST_ROT2, mop >= OP_END1, "heading not ready")
  `PDR_ASSERT_SAME(a_cordic_in_rot, cord_rsp.busy, state == ST_ROT1 || state == ST_ROT2, "cordic stray")

endmodule

// ----- hdl/pdr_cordic.sv -----
`timescale 1ns / 1ps

module pdr_cordic (
  input  logic               clk,
  input  logic               rst,
  input  pdr_pkg::cord_req_t req,
  output pdr_pkg::cord_rsp_t rsp
);

  logic signed [pdr_pkg::CW-1:0] x;
  logic signed [pdr_pkg::CW-1:0] y;
  logic signed [pdr_pkg::CW-1:0] z;
  logic                          flip;
  logic                          busy;
  logic [pdr_pkg::STEP_W-1:0]    step;

  logic signed [pdr_pkg::CW-1:0] xs;
  logic signed [pdr_pkg::CW-1:0] ys;
  logic signed [pdr_pkg::CW-1:0] at;
  logic signed [pdr_pkg::CW-1:0] ang;
  logic signed [pdr_pkg::CW-1:0] ang_adj;
  logic                          ang_flip;

  always_comb begin
    xs  = x >>> step;
    ys  = y >>> step;
    at  = $signed({{(pdr_pkg::CW-30){1'b0}}, pdr_pkg::atan_step(step)});
    ang = pdr_pkg::CW'(req.angle);
    priority if (ang > pdr_pkg::QUARTER_TURN) begin
      ang_adj  = ang - pdr_pkg::HALF_TURN;
      ang_flip = 1'b1;
    end else if (ang < -pdr_pkg::QUARTER_TURN) begin
      ang_adj  = ang + pdr_pkg::HALF_TURN;
      ang_flip = 1'b1;
    end else begin
      ang_adj  = ang;
      ang_flip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      step <= '0;
      x    <= pdr_pkg::CORDIC_GAIN_Q30;
      y    <= '0;
      z    <= ang_adj;
      flip <= ang_flip;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
      if (step == pdr_pkg::STEP_W'(pdr_pkg::CORDIC_ITERS - 1)) begin
        busy <= 1'b0;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  assign rsp.busy    = busy;
  assign rsp.cos_q30 = flip ? -x : x;
  assign rsp.sin_q30 = flip ? -y : y;

endmodule

// ----- dv/pose_report_checker.sv -----
`timescale 1ns / 1ps

module pose_report_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  // linear_velocity[15:0], angular_velocity[31:16], elapsed_time[47:32]
  input  logic [47:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  // position_x[31:0], position_y[63:32], heading[79:64], quat_z[95:80],
  // quat_w[111:96], speed_linear[127:112], speed_angular[143:128]
  input  logic [143:0] m_tdata,
  output int           mismatches,
  output int           awaiting
);

  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam longint QUARTER     = 64'sd1073741824;
  localparam longint HALF        = 64'sd2147483648;
  localparam longint TURN_PER_PI = 64'sd1367130551;
  localparam int     ROT_STEPS   = (pdr_pkg::CORDIC_STEPS > 24) ? 24 : pdr_pkg::CORDIC_STEPS;

  typedef struct packed {
    logic [15:0]        elapsed_time;
    logic signed [15:0] angular_velocity;
    logic signed [15:0] linear_velocity;
  } drive_update_t;

  typedef struct packed {
    logic signed [15:0] speed_angular;
    logic signed [15:0] speed_linear;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_z;
    logic signed [15:0] heading;
    logic signed [31:0] position_y;
    logic signed [31:0] position_x;
  } pose_report_t;

  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [15:0] yaw   = '0;
  pose_report_t       expected_reports[$];
  int                 errs  = 0;

  // arctan(2^-i), 2^32 per turn
  function automatic longint arctan_turn(input int i);
    case (i)
      0:  return 536870912;
      1:  return 316933406;
      2:  return 167458907;
      3:  return 85004756;
      4:  return 42667331;
      5:  return 21354465;
      6:  return 10679838;
      7:  return 5340245;
      8:  return 2670163;
      9:  return 1335087;
      10: return 667544;
      11: return 333772;
      12: return 166886;
      13: return 83443;
      14: return 41722;
      15: return 20861;
      16: return 10430;
      17: return 5215;
      18: return 2608;
      19: return 1304;
      20: return 652;
      21: return 326;
      22: return 163;
      23: return 81;
      default: return 0;
    endcase
  endfunction

  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  function automatic logic signed [15:0] clamp_q15(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // rotation-mode CORDIC, Q30 out; angles past a quarter turn are folded by a half turn
  function automatic void rotate(input longint ang, output longint c, output longint s);
    longint x, y, z, nx;
    bit     flip;
    x    = GAIN_Q30;
    y    = 0;
    z    = ang;
    flip = 1'b0;
    if (z > QUARTER) begin
      z    = z - HALF;
      flip = 1'b1;
    end else if (z < -QUARTER) begin
      z    = z + HALF;
      flip = 1'b1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - arctan_turn(i);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + arctan_turn(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic pose_report_t advance_pose(input drive_update_t u);
    pose_report_t r;
    longint       v, w, dt, c, s, vdt, dh, qc, qs;
    v  = u.linear_velocity;
    w  = u.angular_velocity;
    dt = u.elapsed_time;
    rotate(longint'(yaw) * 65536, c, s);
    vdt   = v * dt;
    pos_x = clamp32(longint'(pos_x) + rnd_shift(vdt * c, 42));
    pos_y = clamp32(longint'(pos_y) + rnd_shift(vdt * s, 42));
    dh    = rnd_shift(w * dt * TURN_PER_PI, 45);
    yaw   = yaw + 16'(dh);
    rotate(longint'(yaw) * 32768, qc, qs);
    r.position_x    = pos_x;
    r.position_y    = pos_y;
    r.heading       = yaw;
    r.quat_z        = clamp_q15(rnd_shift(qs, 15));
    r.quat_w        = clamp_q15(rnd_shift(qc, 15));
    r.speed_linear  = u.linear_velocity;
    r.speed_angular = u.angular_velocity;
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errs++;
      $error("%s expected %0d got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    pose_report_t got, want;
    if (rst) begin
      pos_x = '0;
      pos_y = '0;
      yaw   = '0;
      expected_reports.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = pose_report_t'(m_tdata);
        if (expected_reports.size() == 0) begin
          errs++;
          $error("result beat with no update pending");
        end else begin
          want = expected_reports.pop_front();
          check_field("position_x", want.position_x, got.position_x);
          check_field("position_y", want.position_y, got.position_y);
          check_field("heading", want.heading, got.heading);
          check_field("quat_z", want.quat_z, got.quat_z);
          check_field("quat_w", want.quat_w, got.quat_w);
          check_field("speed_linear", want.speed_linear, got.speed_linear);
          check_field("speed_angular", want.speed_angular, got.speed_angular);
        end
      end
      if (s_tvalid && s_tready)
        expected_reports.push_back(advance_pose(drive_update_t'(s_tdata)));
    end
    mismatches <= errs;
    awaiting   <= expected_reports.size();
  end

endmodule

// ----- dv/pose_dead_reckoning_integrator_top_tb.sv -----
`timescale 1ns / 1ps

module pose_dead_reckoning_integrator_top_tb;

  localparam int CYCLE_LIMIT    = 3000000;
  localparam int RANDOM_UPDATES = 600;
  localparam int LEG_UPDATES    = 50;

  logic               clk;
  logic               rst          = 1'b1;
  logic               s_tvalid     = 1'b0;
  logic               s_tready;
  logic [47:0]        s_tdata      = '0;
  logic               m_tvalid;
  logic               m_tready     = 1'b0;
  logic [143:0]       m_tdata;
  logic               calm         = 1'b0;
  logic signed [15:0] last_heading = '0;
  int                 cycles       = 0;
  int                 sent         = 0;
  int                 mismatches;
  int                 awaiting;

  pose_dead_reckoning_integrator_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  pose_report_checker report_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) last_heading <= m_tdata[79:64];
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("pose_dead_reckoning_integrator_top_tb NOT OK");
      $finish;
    end
  end

  task automatic send_update(input logic signed [15:0] v, input logic signed [15:0] w,
                             input logic [15:0] dt);
    while (!calm && $urandom_range(99) < 36) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {dt, w, v};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_random();
    logic [15:0] dt;
    case ($urandom_range(7))
      0:       dt = 16'h0000;
      1:       dt = 16'hffff;
      default: dt = 16'($urandom);
    endcase
    send_update(16'($urandom), 16'($urandom), dt);
  endtask

  // full-speed straight run
  task automatic drive_leg();
    repeat (LEG_UPDATES)
      send_update(16'($urandom_range(32767, 32700)), 16'sd0, 16'($urandom_range(65535, 65400)));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  initial begin
    int w_home;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_update(16'sd0, 16'sd0, 16'd0);          // zero time, quat_w clamps at 1.0
    send_update(16'sd0, 16'sd12868, 16'hffff);   // heading lands on exactly pi
    send_update(16'sd32767, 16'sd0, 16'hffff);   // half-turn fold at -pi
    send_update(16'sd0, -16'sd6434, 16'hffff);   // heading to a quarter turn
    send_update(16'sd32767, 16'sd0, 16'hffff);   // fold boundary, not folded
    send_update(16'sd0, 16'sd1, 16'd25736);      // one step past quarter turn
    send_update(-16'sd32768, 16'sd0, 16'hffff);
    send_update(16'sd32767, 16'sd32767, 16'hffff);
    send_update(-16'sd32768, -16'sd32768, 16'hffff);
    send_update(16'sd1, 16'sd1, 16'd1);
    send_update(-16'sd1, -16'sd1, 16'd1);
    send_update(-16'sd32768, 16'sd32767, 16'd0);
    send_update(16'sd32767, -16'sd32768, 16'hffff);
    send_update(16'sd21845, -16'sd21846, 16'haaaa);
    send_update(-16'sd21846, 16'sd21845, 16'h5555);
    send_update(16'sd0, 16'sd0, 16'hffff);

    for (int n = 0; n < RANDOM_UPDATES; n++) begin
      calm <= (n >= 250 && n < 400);
      send_random();
    end
    calm <= 1'b0;

    // point back along +x and run, then turn to -y and run
    drain();
    w_home = -(int'(last_heading) * 25736) / 65535;
    send_update(16'sd0, 16'(w_home), 16'hffff);
    drive_leg();
    send_update(16'sd0, -16'sd8192, 16'd51472);
    drive_leg();
    repeat (20) send_random();

    drain();
    repeat (50) @(posedge clk);
    $display("%0d updates: corner cases, random traffic with stalls, and two full-speed",
             sent);
    $display("straight legs, with heading wrap and zero-time updates");
    if (mismatches == 0 && awaiting == 0) begin
      $display("pose_dead_reckoning_integrator_top_tb OK");
    end else begin
      $display("pose_dead_reckoning_integrator_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/pdr_pkg.sv
hdl/pdr_cordic.sv
hdl/pose_dead_reckoning_integrator_top.sv
dv/pose_report_checker.sv
dv/pose_dead_reckoning_integrator_top_tb.sv
